>>> src/kidw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kidw_pkg
// shared types and constants for the inverse distance weighting block
// ---------------------------------------------------------------------------
package kidw_pkg;

  localparam int CoordW = 20;
  localparam int DistW  = 42;
  localparam int SqrtW  = 32;   // isqrt of a value below 2^62
  localparam int RelW   = 32;   // q1.31 relative weight
  localparam int SumW   = 37;   // sum of up to 16 relative weights
  localparam int WgtW   = 17;

  localparam logic [0:0] OpLoad  = 1'b0;
  localparam logic [0:0] OpQuery = 1'b1;

  localparam logic [1:0] CfgMaxInf = 2'd0;
  localparam logic [1:0] CfgMode   = 2'd1;
  localparam logic [1:0] CfgCount  = 2'd2;

  localparam logic [1:0] ModeOffset = 2'd0;
  localparam logic [1:0] ModeSmooth = 2'd1;
  localparam logic [1:0] ModeRigid  = 2'd2;

  // request sent from the scan engine to the iterative divider
  typedef struct packed {
    logic             start;
    logic [62:0]      num;
    logic [SumW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [62:0]      quo;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> src/knn_inverse_distance_weights.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// knn_inverse_distance_weights
// k nearest guide roots of a strand root with normalized inverse distance weights
// ---------------------------------------------------------------------------
// a load request writes one guide root into the on-chip table (no result). a
// query request scans guides 0..guide_count-1 (at least one, at most
// MAX_GUIDES) from the table, one per cycle through a read-then-compute
// pipeline, keeping the k nearest in a small sorted register list. then for
// each kept guide a serial square root, a serial divide, zero to two squaring
// steps (exponent 1, 2 or 4) and an accumulate step make the relative weight;
// a second serial divide per guide normalizes. the query time is set by the
// table scan and the shared bit-serial sqrt and divide units. one request is
// worked at a time; the result register lets the next request enter while
// the last result still waits.
module knn_inverse_distance_weights #(
  parameter int MAX_GUIDES     = 1024,
  parameter int MAX_INFLUENCES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [0:0]  in_operation,
  input  wire logic [9:0]  in_guide_slot,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic signed [19:0] in_pos_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_guide_index,
  output logic [16:0]      out_weight,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import kidw_pkg::*;

  localparam int AW = (MAX_GUIDES > 1) ? $clog2(MAX_GUIDES) : 1;
  localparam int KW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int NW = $clog2(MAX_GUIDES + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_SQRT  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SQ1   = 9'b000010000,
    S_SQ2   = 9'b000100000,
    S_NORM  = 9'b001000000,
    S_NWAIT = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [2:0]  max_inf_r;
  logic [1:0]  mode_r;
  logic [10:0] gcount_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_inf_r <= 3'd4;
      mode_r    <= ModeOffset;
      gcount_r  <= 11'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgMaxInf: max_inf_r <= cfg_data[2:0];
        CfgMode:   mode_r    <= cfg_data[1:0];
        CfgCount:  gcount_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // guide table: one write port, one registered read port
  logic [3*CoordW-1:0] mem [MAX_GUIDES];
  logic [3*CoordW-1:0] rd_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_pos_x, in_pos_y, in_pos_z};
    rd_r <= mem[rd_addr];
  end

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_operation == OpLoad) &&
                    ({22'd0, in_guide_slot} < 32'(MAX_GUIDES));
  assign wr_addr  = AW'(in_guide_slot);

  // query state
  logic signed [CoordW-1:0] qx_r, qy_r, qz_r;
  logic [NW-1:0] n_r, scan_r;
  logic [KW:0]   k_r, cnt_r, idx_r;
  logic [1:0]    qmode_r;
  logic          rd_v_r;
  logic [AW-1:0] rd_g_r;
  logic [DistW-1:0] kd_r [MAX_INFLUENCES];
  logic [9:0]       ki_r [MAX_INFLUENCES];
  logic [RelW-1:0]  rel_r [MAX_INFLUENCES];
  logic [SumW-1:0]  sum_r;
  logic [SqrtW-1:0] s0_r;
  logic [RelW-1:0]  t_r;

  assign rd_addr = AW'(scan_r);

  // squared distance of the entry read last cycle
  logic signed [CoordW:0] dx, dy, dz;
  logic [DistW-1:0] dsq;
  always_comb begin
    dx  = 21'(signed'(rd_r[59:40])) - 21'(qx_r);
    dy  = 21'(signed'(rd_r[39:20])) - 21'(qy_r);
    dz  = 21'(signed'(rd_r[19:0]))  - 21'(qz_r);
    dsq = DistW'(dx * dx) + DistW'(dy * dy) + DistW'(dz * dz);
  end

  // sorted insertion: entries strictly farther than the new one shift down
  logic            ins;
  logic [KW:0]     cnt_ins;
  always_comb begin
    ins     = 1'b0;
    cnt_ins = cnt_r;
    if (cnt_r < k_r) begin
      ins = 1'b1; cnt_ins = cnt_r + 1'b1;
    end else if (dsq < kd_r[KW'(cnt_r - 1'b1)]) begin
      ins = 1'b1;
    end
  end

  // shared arithmetic units
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [KW:0] sq_idx;
  logic [DistW-1:0] dcl;
  // the next root starts as the accumulate step moves on to the next guide
  assign sq_idx = (state_r == S_SQ2) ? idx_r + 1'b1 : idx_r;
  assign dcl = (kd_r[KW'(sq_idx)] == '0) ? DistW'(1) : kd_r[KW'(sq_idx)];
  kidw_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .val({dcl[41:0], 20'd0}),
    .done(sq_done), .root(sq_root)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  kidw_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  logic [63:0] prod;
  assign prod = t_r * t_r;

  logic [WgtW-1:0] wgt_r;
  logic            ov_r;
  logic [9:0]      oi_r;
  logic            ol_r;
  logic            emit_go;

  // squaring pass counter for rigid mode
  logic sqp_r;

  // a result enters the output register when it is empty or being taken
  assign emit_go = (state_r == S_EMIT) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    dreq      = '0;
    unique case (state_r)
      S_IDLE:  if (accept && in_operation == OpQuery) state_nxt = S_SCAN;
      S_SCAN:  if (!rd_v_r && scan_r == n_r) begin
        state_nxt = S_SQRT; sq_start = 1'b1;
      end
      S_SQRT:  if (sq_done) begin
        state_nxt  = S_DIV;
        dreq.start = 1'b1;
        dreq.num   = {(idx_r == '0) ? sq_root : s0_r, 31'd0};
        dreq.den   = SumW'(sq_root);
      end
      S_DIV:   if (drsp.done) state_nxt = (qmode_r == ModeSmooth) ? S_SQ2 : S_SQ1;
      S_SQ1:   state_nxt = (qmode_r == ModeRigid && !sqp_r) ? S_SQ1 : S_SQ2;
      S_SQ2:   if (idx_r + 1'b1 == cnt_r) state_nxt = S_NORM;
               else begin state_nxt = S_SQRT; sq_start = 1'b1; end
      S_NORM:  begin
        state_nxt  = S_NWAIT;
        dreq.start = 1'b1;
        dreq.num   = {15'd0, rel_r[KW'(idx_r)], 16'd0};
        dreq.den   = sum_r;
      end
      S_NWAIT: if (drsp.done) state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = (idx_r + 1'b1 == cnt_r) ? S_IDLE : S_NORM;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_v_r  <= 1'b0;
      ov_r    <= 1'b0;
      ol_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) ov_r <= 1'b1;
      else if (out_valid && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept && in_operation == OpQuery) begin
          qx_r <= in_pos_x; qy_r <= in_pos_y; qz_r <= in_pos_z;
          n_r  <= (gcount_r == 0) ? NW'(1) :
                  ({21'd0, gcount_r} > 32'(MAX_GUIDES)) ? NW'(MAX_GUIDES) : NW'(gcount_r);
          k_r  <= (max_inf_r == 0) ? (KW+1)'(1) :
                  ({29'd0, max_inf_r} > 32'(MAX_INFLUENCES)) ? (KW+1)'(MAX_INFLUENCES)
                                                              : (KW+1)'(max_inf_r);
          qmode_r <= mode_r;
          scan_r <= '0; cnt_r <= '0; idx_r <= '0; rd_v_r <= 1'b0;
          sum_r <= '0;
        end
        S_SCAN: begin
          rd_v_r <= (scan_r != n_r);
          rd_g_r <= AW'(scan_r);
          if (scan_r != n_r) scan_r <= scan_r + 1'b1;
          if (rd_v_r && ins) begin
            cnt_r <= cnt_ins;
            for (int i = MAX_INFLUENCES - 1; i >= 1; i--) begin
              if (i < cnt_ins) begin
                if (dsq < kd_r[i-1]) begin
                  kd_r[i] <= kd_r[i-1]; ki_r[i] <= ki_r[i-1];
                end else if (i >= cnt_r || dsq < kd_r[i]) begin
                  kd_r[i] <= dsq; ki_r[i] <= 10'(rd_g_r);
                end
              end
            end
            if (cnt_r == '0 || dsq < kd_r[0]) begin
              kd_r[0] <= dsq; ki_r[0] <= 10'(rd_g_r);
            end
          end
        end
        S_SQRT: if (sq_done) begin
          if (idx_r == '0) s0_r <= sq_root;
          sqp_r <= 1'b0;
        end
        S_DIV: if (drsp.done) t_r <= RelW'(drsp.quo);
        S_SQ1: begin
          t_r   <= RelW'(prod >> 31);
          sqp_r <= 1'b1;
        end
        S_SQ2: begin
          rel_r[KW'(idx_r)] <= t_r;
          sum_r <= sum_r + SumW'(t_r);
          idx_r <= (idx_r + 1'b1 == cnt_r) ? '0 : idx_r + 1'b1;
        end
        S_EMIT: if (emit_go) begin
          oi_r  <= ki_r[KW'(idx_r)];
          wgt_r <= WgtW'(drsp.quo);
          ol_r  <= (idx_r + 1'b1 == cnt_r);
          if (idx_r + 1'b1 != cnt_r) idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_guide_index = oi_r;
  assign out_weight      = wgt_r;
  assign out_last        = ol_r;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !accept) else $error("request taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= k_r || state_r == S_IDLE) else $error("kept list overflow");
endmodule
`default_nettype wire

>>> src/kidw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kidw_div
// restoring divider, one quotient bit per cycle, 63-bit numerator
// ---------------------------------------------------------------------------
module kidw_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kidw_pkg::div_req_t req,
  output kidw_pkg::div_rsp_t      rsp
);
  import kidw_pkg::*;

  logic [62:0]     quo_r, quo_nxt;
  logic [SumW:0]   rem_r, rem_nxt;
  logic [SumW-1:0] den_r;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [SumW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[SumW-1:0], quo_r[62]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[61:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[61:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule
`default_nettype wire

>>> src/kidw_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kidw_sqrt
// bit-pair integer square root of a 62-bit value, one result bit per cycle
// ---------------------------------------------------------------------------
module kidw_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [61:0] val,
  output logic             done,
  output logic [31:0]      root
);
  import kidw_pkg::*;

  logic [61:0] v_r, v_nxt;
  logic [31:0] r_r, r_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] trial, test;

  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], v_r[61:60]};
    test     = {r_r, 2'b01};
    if (start) begin
      v_nxt    = val;
      r_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = 5'd30;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[59:0], 2'b00};
      if (trial >= test) begin
        rem_nxt = trial - test;
        r_nxt   = {r_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        r_nxt   = {r_r[30:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign root = r_r;
endmodule
`default_nettype wire
